FILE: rtl/tlpt_pkg.sv
// Shared constants, codes and control types for the two-level page table.
package tlpt_pkg;

  localparam int PAGE_SHIFT          = 12;
  localparam int SECOND_INDEX_BITS   = 6;
  localparam int FIRST_LEVEL_ENTRIES = 16;

  localparam int VADDR_W = 32;
  localparam int DATA_W  = 32;
  localparam int OP_W    = 2;

  localparam int SECOND_LEVEL_ENTRIES = 1 << SECOND_INDEX_BITS;
  localparam int TABLE_DEPTH          = FIRST_LEVEL_ENTRIES * SECOND_LEVEL_ENTRIES;
  localparam int SLOT_W               = $clog2(TABLE_DEPTH);

  // The valid map is kept as words of up to 32 bits; a word never spans two
  // second-level tables, so the word count is exact.
  localparam int WORD_BITS = (SECOND_INDEX_BITS < 5) ? SECOND_INDEX_BITS : 5;
  localparam int WORD_W    = 1 << WORD_BITS;
  localparam int NWORDS    = TABLE_DEPTH >> WORD_BITS;
  localparam int WIDX_W    = SLOT_W - WORD_BITS;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_PAY_W   = 1 + DATA_W + VADDR_W;
  localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_ADD       = 2'd0;
  localparam op_t OP_LOOKUP    = 2'd1;
  localparam op_t OP_REMOVE    = 2'd2;
  localparam op_t OP_FIND_NEXT = 2'd3;

  typedef struct packed {
    logic acc;        // take the request, read its map word and entry
    logic clr_wr;     // clear the current map word, advance
    logic scan_next;  // read the following map word
    logic load;       // load the result register, commit writes
  } dp_cmd_t;

  typedef struct packed {
    logic last_word;
    logic hit;
    logic is_find;
    logic oor;
  } dp_sts_t;

endpackage

FILE: rtl/tlpt_dp.sv
// Datapath: request registers, valid map and entry memories, scan logic, result register.
module tlpt_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tlpt_pkg::dp_cmd_t                  cmd,
  input  logic [tlpt_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [tlpt_pkg::OP_W-1:0]          in_tuser,
  output tlpt_pkg::dp_sts_t                  sts,
  output logic [tlpt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [0:0]                         out_tuser
);

  localparam int SW = tlpt_pkg::SLOT_W;
  localparam int WB = tlpt_pkg::WORD_BITS;
  localparam int WW = tlpt_pkg::WORD_W;
  localparam int XW = tlpt_pkg::WIDX_W;
  localparam int VW = tlpt_pkg::VADDR_W;
  localparam int DW = tlpt_pkg::DATA_W;

  logic [WW-1:0] vmap_mem [tlpt_pkg::NWORDS];
  logic [DW-1:0] ent_mem  [tlpt_pkg::TABLE_DEPTH];

  logic [VW-1:0]       in_vaddr;
  logic [VW-1:0]       in_page;
  logic [VW-1:0]       in_first;
  logic                in_oor;
  logic [SW-1:0]       in_slot;

  tlpt_pkg::op_t       op_r;
  logic [SW-1:0]       slot_r;
  logic [DW-1:0]       data_r;
  logic                oor_r;
  logic                first_r;
  logic [XW-1:0]       widx_r, widx_nxt;
  logic [WW-1:0]       vmap_q_r;
  logic [DW-1:0]       ent_q_r;
  logic [tlpt_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                out_tuser_r;

  logic                rd_en;
  logic [XW-1:0]       rd_addr;
  logic                wr_en;
  logic [WW-1:0]       wr_data;
  logic                ent_wr;
  logic [WB-1:0]       bpos;
  logic [WW-1:0]       bitmask;
  logic [WW-1:0]       above;
  logic [WW-1:0]       cand;
  logic [WB-1:0]       pos;
  logic                hit;
  logic                vbit;
  logic [SW-1:0]       hit_slot;
  logic [VW-1:0]       va_wide;
  logic                res_found;
  logic [DW-1:0]       res_entry;
  logic [VW-1:0]       res_next;

  assign in_vaddr = in_tdata[VW-1:0];
  assign in_page  = in_vaddr >> tlpt_pkg::PAGE_SHIFT;
  assign in_first = in_page >> tlpt_pkg::SECOND_INDEX_BITS;
  assign in_oor   = (in_first >= VW'(tlpt_pkg::FIRST_LEVEL_ENTRIES));
  assign in_slot  = in_page[SW-1:0];

  assign rd_en   = (cmd.acc && !in_oor) || cmd.scan_next;
  assign rd_addr = cmd.acc ? in_slot[SW-1:WB] : XW'(widx_r + XW'(1));

  assign bpos    = slot_r[WB-1:0];
  assign bitmask = WW'(1) << bpos;
  assign above   = ~(bitmask | (bitmask - WW'(1)));
  assign cand    = vmap_q_r & (first_r ? above : {WW{1'b1}});
  assign hit     = |cand;
  assign vbit    = |(vmap_q_r & bitmask);

  // Lowest set bit of the candidate word.
  always_comb begin
    pos = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = WB'(i);
      end
    end
  end

  assign hit_slot = {widx_r, pos};
  assign va_wide  = VW'({hit_slot, {tlpt_pkg::PAGE_SHIFT{1'b0}}});

  always_comb begin
    wr_en   = 1'b0;
    wr_data = vmap_q_r;
    ent_wr  = 1'b0;
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_data = '0;
    end else if (cmd.load && !oor_r) begin
      case (op_r)
        tlpt_pkg::OP_ADD: begin
          wr_en   = 1'b1;
          wr_data = vmap_q_r | bitmask;
          ent_wr  = 1'b1;
        end
        tlpt_pkg::OP_REMOVE: begin
          wr_en   = 1'b1;
          wr_data = vmap_q_r & ~bitmask;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    res_found = 1'b0;
    res_entry = '0;
    res_next  = '0;
    if (!oor_r) begin
      case (op_r)
        tlpt_pkg::OP_LOOKUP: begin
          res_found = vbit;
          res_entry = vbit ? ent_q_r : '0;
        end
        tlpt_pkg::OP_FIND_NEXT: begin
          res_found = hit;
          res_next  = hit ? va_wide : '0;
        end
        default: begin
          res_found = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    widx_nxt = widx_r;
    if (cmd.acc) begin
      widx_nxt = in_slot[SW-1:WB];
    end else if (cmd.scan_next || cmd.clr_wr) begin
      widx_nxt = XW'(widx_r + XW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
    end else begin
      widx_r <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      op_r    <= in_tuser;
      slot_r  <= in_slot;
      data_r  <= in_tdata[VW +: DW];
      oor_r   <= in_oor;
    end
    if (cmd.acc) begin
      first_r <= 1'b1;
    end else if (cmd.scan_next) begin
      first_r <= 1'b0;
    end
    if (cmd.load) begin
      out_tdata_r <= tlpt_pkg::OUT_TDATA_W'({res_next, res_entry, res_found});
      out_tuser_r <= oor_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      vmap_q_r <= vmap_mem[rd_addr];
    end
    if (wr_en) begin
      vmap_mem[widx_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && !in_oor) begin
      ent_q_r <= ent_mem[in_slot];
    end
    if (ent_wr) begin
      ent_mem[slot_r] <= data_r;
    end
  end

  assign sts.last_word = (widx_r == XW'(tlpt_pkg::NWORDS - 1));
  assign sts.hit       = hit;
  assign sts.is_find   = (op_r == tlpt_pkg::OP_FIND_NEXT);
  assign sts.oor       = oor_r;

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule

FILE: rtl/tlpt_ctrl.sv
// Controller: clearing pass, request acceptance, scan sequencing and result valid.
module tlpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  tlpt_pkg::dp_sts_t sts,
  output tlpt_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       done;

  assign out_free = !out_valid_r || out_tready;
  // A request finishes once its answer is known: error, not a search, hit or table end.
  assign done     = sts.oor || !sts.is_find || sts.hit || sts.last_word;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.last_word) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.acc   = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!done) begin
          cmd.scan_next = 1'b1;
        end else if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

FILE: rtl/two_level_page_table.sv
// Top level of the two-level page table: controller plus datapath.
//
// Requests enter on the in_ stream: in_tuser carries the op (add, lookup,
// remove, find next valid page), in_tdata the virtual address and the entry
// word for an add. Each request yields one result on the out_ stream:
// out_tdata carries found, the entry word and the next page address,
// out_tuser the status (set when the address lies beyond the table).
// Add, lookup and remove read the valid map word and the entry memory on
// acceptance, then check, write back and load the result. Find-next scans
// the valid map one 32-bit word per cycle, reading at most NWORDS - 1
// further words (31 with the default table). The next request is accepted
// in the cycle after the result is loaded.
// After reset the valid map is swept clear, one word per cycle, all NWORDS
// words (32 by default); in_tready stays low meanwhile. A result waits in
// the output register while out_tready is low; the block holds a finished
// request until that register can take its result.
module two_level_page_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tlpt_pkg::IN_TDATA_W-1:0]    in_tdata,   // vaddr[31:0], entry_data[63:32]
  input  logic [tlpt_pkg::OP_W-1:0]          in_tuser,   // op[1:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tlpt_pkg::OUT_TDATA_W-1:0]   out_tdata,  // found[0], entry_out[32:1],
                                                         // next_vaddr[64:33], zero pad
  output logic [0:0]                         out_tuser   // status[0]
);

  tlpt_pkg::dp_cmd_t cmd;
  tlpt_pkg::dp_sts_t sts;

  tlpt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tlpt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

FILE: rtl/tlpt_checker.sv
// Port-level checks on the page table's request and result streams, bound to the top level.
module tlpt_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [tlpt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic [0:0]                         out_tuser
);

  localparam int DW = tlpt_pkg::DATA_W;
  localparam int VW = tlpt_pkg::VADDR_W;

  // One request in flight: drop ready after a request is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in flight");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // An out-of-range request answers with nothing but the error flag.
  a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("error result carries data");

  // A miss carries neither an entry word nor a page address.
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[DW+VW:1] == '0)
    else $error("miss result carries data");

  // Lookup and find-next answers never mix.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DW:1] == '0) || (out_tdata[DW+VW:DW+1] == '0))
    else $error("entry word and page address both set");

endmodule

bind two_level_page_table tlpt_checker u_tlpt_checker (.*);

FILE: sim/two_level_page_table_tb.sv
// Self-checking stream testbench for the two-level page table: directed and random requests.
`timescale 1ns / 100ps

module two_level_page_table_tb;

  typedef struct packed {
    logic                         found;
    logic [tlpt_pkg::DATA_W-1:0]  entry_out;
    logic [tlpt_pkg::VADDR_W-1:0] next_vaddr;
    logic                         status;
  } pt_reply_t;

  // Shadow page table: predicts the reply to every accepted request and checks
  // the replies in order.
  class pte_tracker;
    bit                          slot_valid [tlpt_pkg::TABLE_DEPTH];
    logic [tlpt_pkg::DATA_W-1:0] slot_entry [tlpt_pkg::TABLE_DEPTH];
    pt_reply_t                   expected_replies [$];
    int unsigned                 fails;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      fails = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function pt_reply_t predict_reply(tlpt_pkg::op_t op, logic [tlpt_pkg::VADDR_W-1:0] va,
                                      logic [tlpt_pkg::DATA_W-1:0] d);
      pt_reply_t                    r;
      logic [tlpt_pkg::VADDR_W-1:0] page;
      int unsigned                  slot;
      r = '0;
      page = va >> tlpt_pkg::PAGE_SHIFT;
      // out of range: nothing changes, status set
      if ((page >> tlpt_pkg::SECOND_INDEX_BITS) >= tlpt_pkg::FIRST_LEVEL_ENTRIES) begin
        r.status = 1'b1;
        return r;
      end
      slot = page;
      case (op)
        tlpt_pkg::OP_ADD: begin
          slot_entry[slot] = d;
          slot_valid[slot] = 1'b1;
        end
        tlpt_pkg::OP_LOOKUP: begin
          if (slot_valid[slot]) begin
            r.found = 1'b1;
            r.entry_out = slot_entry[slot];
          end
        end
        tlpt_pkg::OP_REMOVE: slot_valid[slot] = 1'b0;
        default: begin
          for (int s = slot + 1; s < tlpt_pkg::TABLE_DEPTH; s++) begin
            if (slot_valid[s]) begin
              r.found = 1'b1;
              r.next_vaddr = tlpt_pkg::VADDR_W'(s) << tlpt_pkg::PAGE_SHIFT;
              break;
            end
          end
        end
      endcase
      return r;
    endfunction

    function void note_request(tlpt_pkg::op_t op, logic [tlpt_pkg::VADDR_W-1:0] va,
                               logic [tlpt_pkg::DATA_W-1:0] d);
      expected_replies.push_back(predict_reply(op, va, d));
    endfunction

    function void report(string what, pt_reply_t want, pt_reply_t got);
      fails++;
      if (fails <= 10)
        $display("%0t %s: exp found=%0b entry=%08h next=%08h status=%0b,",
                 $realtime, what, want.found, want.entry_out, want.next_vaddr, want.status,
                 " got found=%0b entry=%08h next=%08h status=%0b",
                 got.found, got.entry_out, got.next_vaddr, got.status);
    endfunction

    function void check_result(logic [tlpt_pkg::OUT_TDATA_W-1:0] td, logic [0:0] tu);
      pt_reply_t got, want;
      got.found      = td[0];
      got.entry_out  = td[32:1];
      got.next_vaddr = td[64:33];
      got.status     = tu[0];
      if (expected_replies.size() == 0) begin
        report("unexpected reply", '0, got);
        return;
      end
      want = expected_replies.pop_front();
      if (got.found !== want.found || got.entry_out !== want.entry_out ||
          got.next_vaddr !== want.next_vaddr || got.status !== want.status)
        report("reply mismatch", want, got);
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [tlpt_pkg::IN_TDATA_W-1:0]   in_tdata;   // vaddr[31:0], entry_data[63:32]
  logic [tlpt_pkg::OP_W-1:0]         in_tuser;   // op[1:0]
  logic                              out_tvalid;
  logic                              out_tready;
  logic [tlpt_pkg::OUT_TDATA_W-1:0]  out_tdata;  // found[0], entry_out[32:1],
                                                 // next_vaddr[64:33], pad
  logic [0:0]                        out_tuser;  // status[0]

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  pte_tracker  sb;

  two_level_page_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Offer one request, with random idle cycles ahead of it; return once taken.
  task automatic send_request(tlpt_pkg::op_t op, logic [tlpt_pkg::VADDR_W-1:0] va,
                              logic [tlpt_pkg::DATA_W-1:0] d);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {d, va};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, va, d);
  endtask

  task automatic send_random();
    int unsigned                  r;
    int unsigned                  slot;
    tlpt_pkg::op_t                op;
    logic [tlpt_pkg::VADDR_W-1:0] va;
    logic [tlpt_pkg::VADDR_W-1:0] table_end;
    table_end = tlpt_pkg::VADDR_W'(tlpt_pkg::TABLE_DEPTH) << tlpt_pkg::PAGE_SHIFT;
    r = $urandom_range(0, 99);
    op = (r < 30) ? tlpt_pkg::OP_ADD : (r < 60) ? tlpt_pkg::OP_LOOKUP :
         (r < 75) ? tlpt_pkg::OP_REMOVE : tlpt_pkg::OP_FIND_NEXT;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // beyond the table: force some first-level bit above the range
      va = $urandom;
      if (va < table_end)
        va = va | (table_end << $urandom_range(0, 9));
    end else begin
      // keep most traffic on a few hot pages so lookups and scans hit
      if (r < 55)      slot = $urandom_range(0, 39);
      else if (r < 75) slot = $urandom_range(tlpt_pkg::TABLE_DEPTH - 24,
                                             tlpt_pkg::TABLE_DEPTH - 1);
      else             slot = $urandom_range(0, tlpt_pkg::TABLE_DEPTH - 1);
      va = (tlpt_pkg::VADDR_W'(slot) << tlpt_pkg::PAGE_SHIFT) |
           tlpt_pkg::VADDR_W'($urandom_range(0, (1 << tlpt_pkg::PAGE_SHIFT) - 1));
    end
    send_request(op, va, $urandom);
  endtask

  initial begin
    logic [tlpt_pkg::VADDR_W-1:0] top_va;
    logic [tlpt_pkg::VADDR_W-1:0] l2_va;
    top_va = (tlpt_pkg::VADDR_W'(tlpt_pkg::TABLE_DEPTH) << tlpt_pkg::PAGE_SHIFT) - 1;
    l2_va  = tlpt_pkg::VADDR_W'(tlpt_pkg::SECOND_LEVEL_ENTRIES) << tlpt_pkg::PAGE_SHIFT;
    sb = new();
    src_idle_pct = 23;
    snk_idle_pct = 84;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = tlpt_pkg::OP_ADD;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: table edges, every op, misses and out-of-range addresses
    send_request(tlpt_pkg::OP_ADD,       32'h0000_0ABC, 32'h0000_0000);
    send_request(tlpt_pkg::OP_ADD,       top_va,        32'hFFFF_FFFF);
    send_request(tlpt_pkg::OP_LOOKUP,    32'h0000_0000, 32'h0);
    send_request(tlpt_pkg::OP_LOOKUP,    top_va,        32'h0);
    send_request(tlpt_pkg::OP_FIND_NEXT, 32'h0000_0FFF, 32'h0);
    send_request(tlpt_pkg::OP_FIND_NEXT, top_va,        32'h0);
    send_request(tlpt_pkg::OP_LOOKUP,    32'h0000_5000, 32'h0);
    send_request(tlpt_pkg::OP_REMOVE,    32'h0000_5123, 32'h0);
    send_request(tlpt_pkg::OP_REMOVE,    32'h0000_0000, 32'h0);
    send_request(tlpt_pkg::OP_LOOKUP,    32'h0000_0000, 32'h0);
    send_request(tlpt_pkg::OP_FIND_NEXT, 32'h0000_0000, 32'h0);
    send_request(tlpt_pkg::OP_ADD,       l2_va,         32'hA5A5_5A5A);
    send_request(tlpt_pkg::OP_FIND_NEXT, l2_va - 32'h1000, 32'h0);
    send_request(tlpt_pkg::OP_ADD,       top_va,        32'h1234_5678);
    send_request(tlpt_pkg::OP_LOOKUP,    top_va & ~32'hFFF, 32'h0);
    send_request(tlpt_pkg::OP_ADD,       top_va + 1,    32'hDEAD_BEEF);
    send_request(tlpt_pkg::OP_LOOKUP,    32'hFFFF_FFFF, 32'h0);
    send_request(tlpt_pkg::OP_REMOVE,    32'hFFFF_F000, 32'h0);
    send_request(tlpt_pkg::OP_FIND_NEXT, 32'h8000_0000, 32'h0);
    send_request(tlpt_pkg::OP_FIND_NEXT, 32'h0000_0000, 32'h0);
    send_request(tlpt_pkg::OP_REMOVE,    top_va,        32'h0);
    send_request(tlpt_pkg::OP_FIND_NEXT, 32'h0000_0000, 32'h0);

    repeat (230) send_random();
    src_idle_pct = 84;
    snk_idle_pct = 23;
    repeat (230) send_random();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (240) send_random();
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // a longest scan is well under this
    repeat (60) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0)
      $display("two_level_page_table_tb: PASS");
    else
      $display("two_level_page_table_tb: FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("two_level_page_table_tb: FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/tlpt_pkg.sv
rtl/tlpt_dp.sv
rtl/tlpt_ctrl.sv
rtl/two_level_page_table.sv
rtl/tlpt_checker.sv
sim/two_level_page_table_tb.sv
